FILE: rtl/bleo_pkg.sv
// ----------------------------------------------------------------------------
// bleo_pkg
// Shared types and codes for the bounded list with oldest-entry eviction.
// ----------------------------------------------------------------------------
package bleo_pkg;

  localparam int FUNC_W = 3;
  localparam int DATA_W = 64;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 4;
  localparam int STAT_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 3'd0,
    FUNC_DISMISS = 3'd1,
    FUNC_READ    = 3'd2,
    FUNC_START   = 3'd3,
    FUNC_STOP    = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE        = 3'd0,
    ST_EVICTED     = 3'd1,
    ST_BAD_PAYLOAD = 3'd2,
    ST_BAD_INDEX   = 3'd3,
    ST_INACTIVE    = 3'd4
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] entry_data;
    logic              payload_valid;
    logic [IDX_W-1:0]  slot_index;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  entry_count;
  } out_item_t;

  // control from the sequencing logic to the entry bank
  typedef struct packed {
    logic drop;
    logic write;
  } store_ctrl_t;

endpackage

FILE: rtl/bleo_chan_if.sv
// ----------------------------------------------------------------------------
// bleo_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface bleo_chan_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

FILE: rtl/bounded_list_evict_oldest.sv
// ----------------------------------------------------------------------------
// bounded_list_evict_oldest
// Ordered list of up to DEPTH entries with append, dismiss, read, start, stop.
// ----------------------------------------------------------------------------
// One operation is taken per clock unless the output stalls, and every
// operation gives exactly one result. An operation waits in the input register
// and its result is written to the result register when it executes, so
// throughput is one item per cycle. The rate is set by the entry bank:
// every position shifts in parallel, so an eviction or a dismiss closes its gap
// in the same cycle that the operation executes. The result register holds a
// finished result until the output takes it; a stall on the output holds the
// input register and then drops ready on the input. There is no clearing pass
// after reset: entries above the count are never read.
module bounded_list_evict_oldest #(
  parameter int DEPTH       = 8,
  parameter int ENTRY_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bleo_chan_if.sink         in_i,
  bleo_chan_if.source       out_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > bleo_pkg::IDX_W) ? CW : bleo_pkg::IDX_W;
  localparam int DW    = bleo_pkg::DATA_W;
  localparam int OCW   = bleo_pkg::CNT_W;

  // input register
  logic                 in_valid_q;
  bleo_pkg::in_item_t   in_item_q;

  // result register
  logic                 out_valid_q;
  bleo_pkg::out_item_t  out_item_q;
  bleo_pkg::out_item_t  out_item_d;

  // list state
  logic                 active_q, active_d;
  logic [CW-1:0]        count_q, count_d;

  logic                 out_free;
  logic                 advance;

  bleo_pkg::store_ctrl_t  ctrl;
  logic [AW-1:0]          drop_pos;
  logic [AW-1:0]          wr_pos;
  logic [ENTRY_WIDTH-1:0] rd_data;
  logic                   full;
  logic                   idx_ok;
  bleo_pkg::status_e      status;
  logic                   rd_hit;

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= in_i.payload;
    end
  end

  assign full   = (count_q == CW'(DEPTH));
  assign idx_ok = (CMP_W'(in_item_q.slot_index) < CMP_W'(count_q));

  always_comb begin
    ctrl       = '0;
    drop_pos   = AW'(in_item_q.slot_index);
    wr_pos     = AW'(count_q);
    status     = bleo_pkg::ST_DONE;
    rd_hit     = 1'b0;
    count_d    = count_q;
    active_d   = active_q;
    case (in_item_q.func)
      bleo_pkg::FUNC_INSERT: begin
        if (!active_q) begin
          status = bleo_pkg::ST_INACTIVE;
        end else if (!in_item_q.payload_valid) begin
          status = bleo_pkg::ST_BAD_PAYLOAD;
        end else if (full) begin
          // evict the oldest and append at the top
          ctrl.drop  = 1'b1;
          ctrl.write = 1'b1;
          drop_pos   = '0;
          wr_pos     = AW'(DEPTH - 1);
          status     = bleo_pkg::ST_EVICTED;
        end else begin
          ctrl.write = 1'b1;
          count_d    = count_q + CW'(1);
        end
      end
      bleo_pkg::FUNC_DISMISS: begin
        if (!active_q) begin
          status = bleo_pkg::ST_INACTIVE;
        end else if (!idx_ok) begin
          status = bleo_pkg::ST_BAD_INDEX;
        end else begin
          ctrl.drop = 1'b1;
          count_d   = count_q - CW'(1);
        end
      end
      bleo_pkg::FUNC_READ: begin
        if (!active_q) begin
          status = bleo_pkg::ST_INACTIVE;
        end else if (!idx_ok) begin
          status = bleo_pkg::ST_BAD_INDEX;
        end else begin
          rd_hit = 1'b1;
        end
      end
      bleo_pkg::FUNC_START: begin
        if (!active_q) begin
          count_d  = '0;
          active_d = 1'b1;
        end
      end
      bleo_pkg::FUNC_STOP: begin
        count_d  = '0;
        active_d = 1'b0;
      end
      default: begin
      end
    endcase
    ctrl.drop  = ctrl.drop && advance;
    ctrl.write = ctrl.write && advance;

    out_item_d.status      = status;
    out_item_d.read_data   = rd_hit ? DW'(rd_data) : '0;
    out_item_d.entry_count = OCW'(count_d);
  end

  bleo_store #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_store (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .drop_pos_i (drop_pos),
    .wr_pos_i   (wr_pos),
    .wr_data_i  (in_item_q.entry_data[ENTRY_WIDTH-1:0]),
    .rd_pos_i   (AW'(in_item_q.slot_index)),
    .rd_data_o  (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        active_q    <= active_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule

FILE: rtl/bleo_store.sv
// ----------------------------------------------------------------------------
// bleo_store
// Entry bank: every position shifts down in parallel to close a gap, then an
// optional write lands at one position. One read tap selected by index.
// ----------------------------------------------------------------------------
module bleo_store #(
  parameter int DEPTH       = 8,
  parameter int ENTRY_WIDTH = 64,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  bleo_pkg::store_ctrl_t         ctrl_i,
  input  logic [AW-1:0]                 drop_pos_i,
  input  logic [AW-1:0]                 wr_pos_i,
  input  logic [ENTRY_WIDTH-1:0]        wr_data_i,
  input  logic [AW-1:0]                 rd_pos_i,
  output logic [ENTRY_WIDTH-1:0]        rd_data_o
);

  logic [ENTRY_WIDTH-1:0] entry_q [DEPTH];
  logic [ENTRY_WIDTH-1:0] entry_d [DEPTH];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_d[i] = entry_q[i];
      // close the gap: positions at or above the dropped one, below the top, take their upper neighbour
      if (ctrl_i.drop && (i < DEPTH - 1) && (AW'(i) >= drop_pos_i)) begin
        entry_d[i] = entry_q[(i < DEPTH - 1) ? i + 1 : i];
      end
      if (ctrl_i.write && (AW'(i) == wr_pos_i)) begin
        entry_d[i] = wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  assign rd_data_o = entry_q[rd_pos_i];

endmodule

FILE: rtl/bleo_checker.sv
// ----------------------------------------------------------------------------
// bleo_checker
// Port-level checks on the result channel of the bounded list.
// ----------------------------------------------------------------------------
module bleo_checker #(
  parameter int DEPTH = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [bleo_pkg::STAT_W-1:0]     status_i,
  input  logic [bleo_pkg::DATA_W-1:0]     read_data_i,
  input  logic [bleo_pkg::CNT_W-1:0]      entry_count_i
);

  localparam int OCW = bleo_pkg::CNT_W;

  // a result that is not taken stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // only a successful read carries data
  a_data_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (read_data_i != '0) |-> status_i == bleo_pkg::ST_DONE)
    else $error("read data with non-done status");

  // an eviction only happens with the list full
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == bleo_pkg::ST_EVICTED) |-> entry_count_i == OCW'(DEPTH))
    else $error("eviction without a full list");

  // an inactive list holds nothing
  a_inactive_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == bleo_pkg::ST_INACTIVE) |-> entry_count_i == '0)
    else $error("inactive list reports entries");

  // the count never exceeds the depth when it fits the field
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (DEPTH >= 16) || (int'(entry_count_i) <= DEPTH))
    else $error("entry count above depth");

endmodule

bind bounded_list_evict_oldest bleo_checker #(
  .DEPTH (DEPTH)
) u_bleo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.payload.status),
  .read_data_i   (out_o.payload.read_data),
  .entry_count_i (out_o.payload.entry_count)
);
